/* design/ottu_pkg.sv */
`timescale 1ns / 1ps
package ottu_pkg;

	localparam int SERIAL_W  = 16;
	localparam int TIMER_W   = 20;
	localparam int ELAPSED_W = 16;
	localparam int GATE_W    = 7;
	localparam int LIMIT_W   = 14;
	localparam int HELD_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_LIFE      = 2'd2;

	localparam logic [GATE_W-1:0]  MATCH_DISTANCE_RST = 7'd50;
	localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST     = 14'd500;
	localparam logic [LIMIT_W-1:0] VIEW_LIFE_RST      = 14'd1000;

	localparam logic OP_DETECTION = 1'b0;
	localparam logic OP_FRAME_END = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MRD,
		ST_MCMP,
		ST_POP,
		ST_ARD,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic upd;
		logic shift;
		logic ins;
	} cell_ctl_t;

	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
		input logic [ELAPSED_W-1:0] b);
		logic [TIMER_W:0] s;
		s = {1'b0, a} + (TIMER_W+1)'(b);
		return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
	endfunction

endpackage

/* design/object_track_table_update_unit.sv */
`timescale 1ns / 1ps
// channel  | dir | handshake             | payload
// s_*      | in  | s_tvalid / s_tready   | s_tdata boxes + elapsed, s_tuser operation
// m_*      | out | m_tvalid / m_tready   | m_tdata track report, m_tuser entry_valid, m_tlast
// cfg_*    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a detection beat is stored and leaves the unit ready for the next beat; a frame end
// walks the head cell over the detection store (one read, one compare) for each track,
// then adds unclaimed detections as new tracks and emits the track report
// the track table is a chain of cells; compaction rotates entries through the head
// arst_n clears control and counters and loads config defaults; table payload is not reset
// input is taken only between frames; results wait in the output register on stall
module object_track_table_update_unit #(
	parameter int MAX_TRACKS     = 16,
	parameter int MAX_DETECTIONS = 16,
	parameter int COORD_BITS     = 11
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// box_left, box_top, box_right, box_bottom, elapsed_ms
	input  logic [((4*COORD_BITS+ottu_pkg::ELAPSED_W+7)/8)*8-1:0] s_tdata,
	// operation
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// track_number, out_left, out_top, out_right, out_bottom, shown, tracks_held, overflow
	output logic [((4*COORD_BITS+23+7)/8)*8-1:0] m_tdata,
	// entry_valid
	output logic m_tuser,
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ottu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ottu_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int CW  = COORD_BITS;
	localparam int BW  = 4*CW;
	localparam int SW  = ottu_pkg::SERIAL_W;
	localparam int TW  = ottu_pkg::TIMER_W;
	localparam int EW  = BW + SW + 2*TW;
	localparam int CTW = $clog2(MAX_TRACKS+1);
	localparam int DTW = $clog2(MAX_DETECTIONS+1);
	localparam int DIW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int SDW = ((BW+ottu_pkg::ELAPSED_W+7)/8)*8;
	localparam int MDW = ((BW+23+7)/8)*8;
	localparam int MFW = BW + 23;

	ottu_pkg::state_t state_q, state_d;

	logic [ottu_pkg::GATE_W-1:0]  match_dist_q;
	logic [ottu_pkg::LIMIT_W-1:0] idle_limit_q, view_life_q;

	logic [CTW-1:0] cnt_q, proc_q, ecnt_q;
	logic [DTW-1:0] j_q, dtotal_q;
	logic [MAX_DETECTIONS-1:0] claimed_q;
	logic drop_q, ovf_q, matched_q;
	logic [ottu_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [SW-1:0] serial_q;

	logic [BW-1:0] dstore_q [MAX_DETECTIONS];
	logic [BW-1:0] drd_q;

	logic [EW-1:0] cell_q [MAX_TRACKS];
	logic [EW-1:0] head, upd_data, ins_data, aged, fresh;
	logic [BW-1:0] h_box, avg_box;
	logic [SW-1:0] h_ser;
	logic [TW-1:0] h_life, h_idle;

	logic upd, shift, ins_en, near, hit, keep, slot_free, s_acc, emit_last;
	logic [CTW-1:0] ins_pos;

	logic [MDW-1:0] out_data_q;
	logic out_user_q, out_last_q, out_valid_q;

	assign s_acc     = s_tvalid && s_tready;
	assign s_tready  = (state_q == ottu_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || m_tready;

	assign head   = cell_q[0];
	assign h_box  = head[BW-1:0];
	assign h_ser  = head[BW +: SW];
	assign h_life = head[BW+SW +: TW];
	assign h_idle = head[BW+SW+TW +: TW];

	for (genvar k = 0; k < 4; k++) begin : g_avg
		logic [CW:0] s;
		assign s = (CW+1)'(h_box[k*CW +: CW]) + (CW+1)'(drd_q[k*CW +: CW]);
		assign avg_box[k*CW +: CW] = s[CW:1];
	end

	assign upd_data = {{TW{1'b0}}, ottu_pkg::sat_add(h_life, elapsed_q), h_ser, avg_box};
	assign aged = {ottu_pkg::sat_add(h_idle, elapsed_q), ottu_pkg::sat_add(h_life, elapsed_q),
		h_ser, h_box};
	assign fresh = {{TW{1'b0}}, {TW{1'b0}}, serial_q, drd_q};

	ottu_dist #(.CW(CW)) u_dist (
		.tbox(h_box),
		.dbox(drd_q),
		.gate(match_dist_q),
		.near(near)
	);

	assign hit  = !claimed_q[j_q[DIW-1:0]] && near;
	assign keep = matched_q || (h_idle < TW'(idle_limit_q));
	assign emit_last = (ecnt_q == cnt_q - CTW'(1));

	// chain of cells; cell 0 is the head
	for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
		ottu_pkg::cell_ctl_t ctl;
		logic [EW-1:0] nbr;
		assign ctl.upd   = upd && (g == 0);
		assign ctl.shift = shift;
		assign ctl.ins   = ins_en && (ins_pos == CTW'(g));
		if (g == MAX_TRACKS-1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_q[g+1];
		end
		ottu_cell #(.W(EW)) u_cell (
			.clk(clk),
			.ctl(ctl),
			.upd_data(upd_data),
			.ins_data(ins_data),
			.nbr(nbr),
			.q(cell_q[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ottu_pkg::ST_IDLE: begin
				if (s_acc && s_tuser == ottu_pkg::OP_FRAME_END) begin
					state_d = (cnt_q == '0) ? ottu_pkg::ST_ARD : ottu_pkg::ST_MRD;
				end
			end
			ottu_pkg::ST_MRD: begin
				state_d = (j_q >= dtotal_q) ? ottu_pkg::ST_POP : ottu_pkg::ST_MCMP;
			end
			ottu_pkg::ST_MCMP: begin
				state_d = hit ? ottu_pkg::ST_POP : ottu_pkg::ST_MRD;
			end
			ottu_pkg::ST_POP: begin
				state_d = (proc_q == CTW'(1)) ? ottu_pkg::ST_ARD : ottu_pkg::ST_MRD;
			end
			ottu_pkg::ST_ARD: begin
				state_d = (j_q >= dtotal_q) ? ottu_pkg::ST_EMIT : ottu_pkg::ST_ADD;
			end
			ottu_pkg::ST_ADD: begin
				state_d = ottu_pkg::ST_ARD;
			end
			ottu_pkg::ST_EMIT: begin
				if (slot_free && (cnt_q == '0 || emit_last)) begin
					state_d = ottu_pkg::ST_IDLE;
				end
			end
			default: state_d = ottu_pkg::ST_IDLE;
		endcase
	end

	// cell chain control
	always_comb begin
		upd      = 1'b0;
		shift    = 1'b0;
		ins_en   = 1'b0;
		ins_pos  = '0;
		ins_data = head;
		case (state_q)
			ottu_pkg::ST_MCMP: begin
				upd = hit;
			end
			ottu_pkg::ST_POP: begin
				// kept entries go behind the ones still waiting
				shift    = 1'b1;
				ins_en   = keep;
				ins_pos  = cnt_q - CTW'(1);
				ins_data = matched_q ? head : aged;
			end
			ottu_pkg::ST_ADD: begin
				ins_en   = !claimed_q[j_q[DIW-1:0]] && (cnt_q < CTW'(MAX_TRACKS));
				ins_pos  = cnt_q;
				ins_data = fresh;
			end
			ottu_pkg::ST_EMIT: begin
				if (slot_free && cnt_q != '0) begin
					shift   = 1'b1;
					ins_en  = 1'b1;
					ins_pos = cnt_q - CTW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == ottu_pkg::OP_DETECTION && dtotal_q < DTW'(MAX_DETECTIONS)) begin
			dstore_q[dtotal_q[DIW-1:0]] <= s_tdata[BW-1:0];
		end
		drd_q <= dstore_q[j_q[DIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ottu_pkg::ST_IDLE;
			match_dist_q <= ottu_pkg::MATCH_DISTANCE_RST;
			idle_limit_q <= ottu_pkg::IDLE_LIMIT_RST;
			view_life_q  <= ottu_pkg::VIEW_LIFE_RST;
			cnt_q        <= '0;
			proc_q       <= '0;
			ecnt_q       <= '0;
			j_q          <= '0;
			dtotal_q     <= '0;
			claimed_q    <= '0;
			drop_q       <= 1'b0;
			ovf_q        <= 1'b0;
			matched_q    <= 1'b0;
			elapsed_q    <= '0;
			serial_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					ottu_pkg::REG_MATCH_DISTANCE: match_dist_q <= cfg_data[ottu_pkg::GATE_W-1:0];
					ottu_pkg::REG_IDLE_LIMIT:     idle_limit_q <= cfg_data;
					ottu_pkg::REG_VIEW_LIFE:      view_life_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && m_tready && !(state_q == ottu_pkg::ST_EMIT && slot_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ottu_pkg::ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == ottu_pkg::OP_FRAME_END) begin
							proc_q    <= cnt_q;
							j_q       <= '0;
							matched_q <= 1'b0;
							ovf_q     <= drop_q;
							elapsed_q <= s_tdata[BW +: ottu_pkg::ELAPSED_W];
						end else if (dtotal_q < DTW'(MAX_DETECTIONS)) begin
							dtotal_q <= dtotal_q + DTW'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ottu_pkg::ST_MCMP: begin
					if (hit) begin
						claimed_q[j_q[DIW-1:0]] <= 1'b1;
						matched_q <= 1'b1;
					end else begin
						j_q <= j_q + DTW'(1);
					end
				end
				ottu_pkg::ST_POP: begin
					proc_q    <= proc_q - CTW'(1);
					j_q       <= '0;
					matched_q <= 1'b0;
					if (!keep) begin
						cnt_q <= cnt_q - CTW'(1);
					end
				end
				ottu_pkg::ST_ARD: begin
					if (j_q >= dtotal_q) begin
						ecnt_q    <= '0;
						dtotal_q  <= '0;
						claimed_q <= '0;
						drop_q    <= 1'b0;
					end
				end
				ottu_pkg::ST_ADD: begin
					j_q <= j_q + DTW'(1);
					if (!claimed_q[j_q[DIW-1:0]]) begin
						if (cnt_q < CTW'(MAX_TRACKS)) begin
							cnt_q    <= cnt_q + CTW'(1);
							serial_q <= serial_q + SW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ottu_pkg::ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						ecnt_q      <= ecnt_q + CTW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (state_q == ottu_pkg::ST_EMIT && slot_free) begin
			if (cnt_q == '0) begin
				out_data_q <= MDW'({ovf_q, {(MFW-1){1'b0}}});
				out_user_q <= 1'b0;
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= MDW'({ovf_q, ottu_pkg::HELD_W'(cnt_q),
					h_life > TW'(view_life_q), h_box, h_ser});
				out_user_q <= 1'b1;
				out_last_q <= emit_last;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CTW'(MAX_TRACKS)) else $error("track count beyond table size");
	a_det_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dtotal_q <= DTW'(MAX_DETECTIONS)) else $error("detection count beyond store size");
	a_proc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		proc_q <= cnt_q) else $error("unprocessed tracks exceed table count");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ottu_pkg::ST_EMIT && state_d == ottu_pkg::ST_IDLE) |=> (dtotal_q == '0))
		else $error("detections left over after frame end");
`endif

endmodule

/* design/ottu_cell.sv */
`timescale 1ns / 1ps
module ottu_cell #(
	parameter int W = 8
) (
	input  logic               clk,
	input  ottu_pkg::cell_ctl_t ctl,
	input  logic [W-1:0]       upd_data,
	input  logic [W-1:0]       ins_data,
	input  logic [W-1:0]       nbr,
	output logic [W-1:0]       q
);

	logic [W-1:0] entry_q;

	// head update wins, then insert, then shift from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			entry_q <= upd_data;
		end else if (ctl.ins) begin
			entry_q <= ins_data;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule

/* design/ottu_dist.sv */
`timescale 1ns / 1ps
module ottu_dist #(
	parameter int CW = 11
) (
	input  logic [4*CW-1:0]             tbox,
	input  logic [4*CW-1:0]             dbox,
	input  logic [ottu_pkg::GATE_W-1:0] gate,
	output logic                        near
);

	logic [CW:0]     tsx, tsy, dsx, dsy, dx, dy;
	logic [2*CW+1:0] dx2, dy2;
	logic [2*CW+2:0] dsum;
	logic [ottu_pkg::GATE_W:0]       g2x;
	logic [2*ottu_pkg::GATE_W+1:0]   g2;

	// doubled centers keep the comparison exact
	always_comb begin
		tsx = (CW+1)'(tbox[0*CW +: CW]) + (CW+1)'(tbox[2*CW +: CW]);
		tsy = (CW+1)'(tbox[1*CW +: CW]) + (CW+1)'(tbox[3*CW +: CW]);
		dsx = (CW+1)'(dbox[0*CW +: CW]) + (CW+1)'(dbox[2*CW +: CW]);
		dsy = (CW+1)'(dbox[1*CW +: CW]) + (CW+1)'(dbox[3*CW +: CW]);
		dx  = (tsx > dsx) ? tsx - dsx : dsx - tsx;
		dy  = (tsy > dsy) ? tsy - dsy : dsy - tsy;
		dx2 = (2*CW+2)'(dx) * (2*CW+2)'(dx);
		dy2 = (2*CW+2)'(dy) * (2*CW+2)'(dy);
		dsum = (2*CW+3)'(dx2) + (2*CW+3)'(dy2);
		g2x = {gate, 1'b0};
		g2  = (2*ottu_pkg::GATE_W+2)'(g2x) * (2*ottu_pkg::GATE_W+2)'(g2x);
		near = dsum < (2*CW+3)'(g2);
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam int N_TRK = 16;
	localparam int N_DET = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		bit [15:0] serial;
		bit [10:0] left, top, right, bottom;
		bit        shown, real_entry;
		bit [4:0]  held;
		bit        ovf, last;
	} track_report_t;

	class track_scoreboard;
		bit [ottu_pkg::GATE_W-1:0]  gate;
		bit [ottu_pkg::LIMIT_W-1:0] idle_lim;
		bit [ottu_pkg::LIMIT_W-1:0] view_life;
		bit [10:0] tl[N_TRK], tt[N_TRK], tr[N_TRK], tb_[N_TRK];
		bit [15:0] ser[N_TRK];
		bit [19:0] life[N_TRK], idle[N_TRK];
		int        n_trk;
		bit [15:0] next_ser;
		bit [10:0] dl[N_DET], dt[N_DET], dr[N_DET], db[N_DET];
		bit        claimed[N_DET];
		int        n_det;
		bit        dropped;
		track_report_t pending[$];
		int errors, reports, frames, placeholders, ovf_frames, shown_reports;

		function new();
			gate = ottu_pkg::MATCH_DISTANCE_RST;
			idle_lim = ottu_pkg::IDLE_LIMIT_RST;
			view_life = ottu_pkg::VIEW_LIFE_RST;
			n_trk = 0;
			next_ser = 0;
			n_det = 0;
			dropped = 0;
		endfunction

		function void set_reg(bit [ottu_pkg::CFG_IDX_W-1:0] idx,
			bit [ottu_pkg::CFG_DAT_W-1:0] val);
			case (idx)
				ottu_pkg::REG_MATCH_DISTANCE: gate = val[ottu_pkg::GATE_W-1:0];
				ottu_pkg::REG_IDLE_LIMIT: idle_lim = val;
				ottu_pkg::REG_VIEW_LIFE: view_life = val;
				default: ;
			endcase
		endfunction

		function bit [19:0] timer_add(bit [19:0] a, bit [15:0] b);
			bit [20:0] s;
			s = {1'b0, a} + 21'(b);
			return s[20] ? 20'hFFFFF : s[19:0];
		endfunction

		function bit close_to(int i, int j);
			longint dx, dy, g;
			dx = longint'(tl[i]) + tr[i] - dl[j] - dr[j];
			dy = longint'(tt[i]) + tb_[i] - dt[j] - db[j];
			g = 2 * longint'(gate);
			return dx * dx + dy * dy < g * g;
		endfunction

		function void note_beat(bit op, bit [10:0] l, bit [10:0] t, bit [10:0] r,
			bit [10:0] b, bit [15:0] el);
			bit hit[N_TRK];
			bit ovf;
			int kept;
			track_report_t rep;
			if (op == ottu_pkg::OP_DETECTION) begin
				if (n_det < N_DET) begin
					dl[n_det] = l; dt[n_det] = t; dr[n_det] = r; db[n_det] = b;
					claimed[n_det] = 0;
					n_det++;
				end else
					dropped = 1;
				return;
			end
			frames++;
			ovf = dropped;
			for (int i = 0; i < n_trk; i++) begin
				hit[i] = 0;
				for (int j = 0; j < n_det; j++) begin
					if (claimed[j] || !close_to(i, j))
						continue;
					tl[i] = (12'(tl[i]) + dl[j]) >> 1;
					tt[i] = (12'(tt[i]) + dt[j]) >> 1;
					tr[i] = (12'(tr[i]) + dr[j]) >> 1;
					tb_[i] = (12'(tb_[i]) + db[j]) >> 1;
					idle[i] = 0;
					life[i] = timer_add(life[i], el);
					claimed[j] = 1;
					hit[i] = 1;
					break;
				end
			end
			kept = 0;
			for (int i = 0; i < n_trk; i++) begin
				if (!hit[i]) begin
					if (idle[i] >= idle_lim)
						continue;
					idle[i] = timer_add(idle[i], el);
					life[i] = timer_add(life[i], el);
				end
				tl[kept] = tl[i]; tt[kept] = tt[i]; tr[kept] = tr[i]; tb_[kept] = tb_[i];
				ser[kept] = ser[i]; life[kept] = life[i]; idle[kept] = idle[i];
				kept++;
			end
			n_trk = kept;
			for (int j = 0; j < n_det; j++) begin
				if (claimed[j])
					continue;
				if (n_trk >= N_TRK) begin
					ovf = 1;
					continue;
				end
				tl[n_trk] = dl[j]; tt[n_trk] = dt[j]; tr[n_trk] = dr[j]; tb_[n_trk] = db[j];
				ser[n_trk] = next_ser;
				life[n_trk] = 0;
				idle[n_trk] = 0;
				next_ser++;
				n_trk++;
			end
			n_det = 0;
			dropped = 0;
			if (ovf)
				ovf_frames++;
			if (n_trk == 0) begin
				rep = '{default: 0};
				rep.ovf = ovf;
				rep.last = 1;
				pending = {pending, rep};
				placeholders++;
				return;
			end
			for (int i = 0; i < n_trk; i++) begin
				rep.serial = ser[i];
				rep.left = tl[i]; rep.top = tt[i]; rep.right = tr[i]; rep.bottom = tb_[i];
				rep.shown = life[i] > view_life;
				rep.real_entry = 1;
				rep.held = 5'(n_trk);
				rep.ovf = ovf;
				rep.last = (i == n_trk - 1);
				if (rep.shown)
					shown_reports++;
				pending = {pending, rep};
			end
		endfunction

		function void check(track_report_t got);
			track_report_t want;
			reports++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected track report: serial %0d", got.serial);
				return;
			end
			want = pending.pop_front();
			if (got != want) begin
				errors++;
				if (errors <= 10)
					$display("report mismatch: want %p got %p", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser, m_tlast;
	logic [71:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [ottu_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ottu_pkg::CFG_DAT_W-1:0] cfg_data;

	track_scoreboard sb = new();
	bit gaps_on;
	int beats_sent;
	int stall_cycles;
	track_report_t seen;

	object_track_table_update_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// output side: random stall bursts while gaps are on
	initial begin
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 19) - 1) @(posedge clk);
			end else begin
				m_tready <= 1;
				repeat ($urandom_range(1, 30) - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen.serial = m_tdata[15:0];
			seen.left = m_tdata[26:16];
			seen.top = m_tdata[37:27];
			seen.right = m_tdata[48:38];
			seen.bottom = m_tdata[59:49];
			seen.shown = m_tdata[60];
			seen.held = m_tdata[65:61];
			seen.ovf = m_tdata[66];
			seen.real_entry = m_tuser;
			seen.last = m_tlast;
			sb.check(seen);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("object_track_table_update_unit verification failed");
			$finish;
		end
	end

	task automatic send_beat(bit op, bit [10:0] l, bit [10:0] t, bit [10:0] r,
		bit [10:0] b, bit [15:0] el);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {4'b0, el, b, r, t, l};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(op, l, t, r, b, el);
		beats_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic write_reg(bit [ottu_pkg::CFG_IDX_W-1:0] idx,
		bit [ottu_pkg::CFG_DAT_W-1:0] val);
		drain();
		repeat (8) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_all(int g, int il, int vl);
		write_reg(ottu_pkg::REG_MATCH_DISTANCE, ottu_pkg::CFG_DAT_W'(g));
		write_reg(ottu_pkg::REG_IDLE_LIMIT, ottu_pkg::CFG_DAT_W'(il));
		write_reg(ottu_pkg::REG_VIEW_LIFE, ottu_pkg::CFG_DAT_W'(vl));
	endtask

	function automatic bit [10:0] nudge(bit [10:0] v, int spread);
		int x;
		x = int'(v) + $urandom_range(0, 2 * spread) - spread;
		return x < 0 ? 11'd0 : (x > 2047 ? 11'd2047 : 11'(x));
	endfunction

	// detections mostly follow existing tracks so that matching gets exercised
	task automatic run_frame(int n, bit [15:0] el);
		int k, sp;
		bit [10:0] l, t, r, b;
		for (int j = 0; j < n; j++) begin
			if (sb.n_trk > 0 && $urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, sb.n_trk - 1);
				sp = $urandom_range(0, 3) == 0 ? 120 : 25;
				l = nudge(sb.tl[k], sp); t = nudge(sb.tt[k], sp);
				r = nudge(sb.tr[k], sp); b = nudge(sb.tb_[k], sp);
			end else begin
				l = $urandom_range(0, 2047); t = $urandom_range(0, 2047);
				r = $urandom_range(0, 2047); b = $urandom_range(0, 2047);
			end
			send_beat(ottu_pkg::OP_DETECTION, l, t, r, b, 16'($urandom_range(0, 65535)));
		end
		send_beat(ottu_pkg::OP_FRAME_END, 11'($urandom), 11'($urandom), 11'($urandom),
			11'($urandom), el);
	endtask

	function automatic bit [15:0] pick_elapsed();
		return $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
	endfunction

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tuser = 0; s_tdata = '0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		gaps_on = 0; beats_sent = 0; stall_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty table first, then corner boxes, too many detections, full timers
		send_beat(ottu_pkg::OP_FRAME_END, 11'd0, 11'd0, 11'd0, 11'd0, 16'd0);
		send_beat(ottu_pkg::OP_DETECTION, 11'd0, 11'd0, 11'd0, 11'd0, 16'd0);
		send_beat(ottu_pkg::OP_DETECTION, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16'hFFFF);
		for (int j = 0; j < 15; j++)
			send_beat(ottu_pkg::OP_DETECTION, 11'(j * 130), 11'(2047 - j * 130),
				11'(j * 130 + 20), 11'(2047 - j * 120), 16'd0);
		send_beat(ottu_pkg::OP_FRAME_END, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16'hFFFF);
		send_beat(ottu_pkg::OP_DETECTION, 11'd0, 11'd0, 11'd1, 11'd1, 16'd0);
		send_beat(ottu_pkg::OP_FRAME_END, 11'd0, 11'd0, 11'd0, 11'd0, 16'hFFFF);
		// no idle allowance: everything unmatched goes, table empties
		set_all(0, 0, 0);
		send_beat(ottu_pkg::OP_FRAME_END, 11'd0, 11'd0, 11'd0, 11'd0, 16'd1);
		send_beat(ottu_pkg::OP_FRAME_END, 11'd0, 11'd0, 11'd0, 11'd0, 16'd0);

		gaps_on = 1;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_all(50, 500, 1000);
				1: set_all(127, 16383, 16383);
				2: set_all(1, 10000, 0);
				3: set_all(100, 10000, 10000);
				default: set_all($urandom_range(0, 127), $urandom_range(0, 16383),
					$urandom_range(0, 16383));
			endcase
			if (ph == 5)
				gaps_on = 0;
			while (beats_sent < 40 + (ph + 1) * 26) begin
				run_frame($urandom_range(0, 9) == 0 ? $urandom_range(12, 18)
					: $urandom_range(0, 6), pick_elapsed());
				if ($urandom_range(0, 9) == 0)
					drain();
			end
		end
		// long-lived tracks with huge steps push life to saturation
		set_all(0, 0, 0);
		send_beat(ottu_pkg::OP_FRAME_END, 11'd0, 11'd0, 11'd0, 11'd0, 16'd0);
		set_all(127, 16383, 16383);
		run_frame(3, 16'hFFFF);
		for (int f = 0; f < 17; f++) begin
			// each track sees its own box again and stays matched
			for (int k = 0; k < sb.n_trk; k++)
				send_beat(ottu_pkg::OP_DETECTION, sb.tl[k], sb.tt[k], sb.tr[k], sb.tb_[k],
					16'd0);
			send_beat(ottu_pkg::OP_FRAME_END, 11'd0, 11'd0, 11'd0, 11'd0, 16'hFFFF);
		end

		drain();
		repeat (700) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.errors++;
		$display("%0d beats in, %0d frames, %0d reports, %0d empty-table, %0d overflow frames",
			beats_sent, sb.frames, sb.reports, sb.placeholders, sb.ovf_frames);
		$display("%0d visible reports, %0d mismatches", sb.shown_reports, sb.errors);
		if (sb.errors == 0)
			$display("object_track_table_update_unit verification clean");
		else
			$display("object_track_table_update_unit verification failed");
		$finish;
	end
endmodule
